FILE: sv/tcq_pkg.sv
// ----------------------------------------------------------------------------
// tcq_pkg: shared types and constants
// Commands, result kinds, controller states and control structs.
// ----------------------------------------------------------------------------
package tcq_pkg;

    localparam int CLASS_DEPTH_DEF  = 32;
    localparam int HANDLE_WIDTH_DEF = 16;
    localparam int LEN_W   = 16;
    localparam int TOS_W   = 8;
    localparam int BYTE_W  = 24;
    localparam int KIND_W  = 3;
    localparam logic [BYTE_W-1:0] LIMIT_RST  = 24'd6553500;
    localparam logic [BYTE_W-1:0] THRESH_RST = 24'd5;
    localparam logic [3:0] TAG_URGENT = 4'h3;
    localparam logic [3:0] TAG_ECN    = 4'h2;

    localparam logic CFG_LIMIT  = 1'b0;
    localparam logic CFG_THRESH = 1'b1;

    typedef enum logic [1:0] {
        CMD_ENQ  = 2'd0,
        CMD_DEQ  = 2'd1,
        CMD_PEEK = 2'd2,
        CMD_NOP  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        K_ACCEPT = 3'd0,
        K_DROP   = 3'd1,
        K_PUSH   = 3'd2,
        K_DEQ    = 3'd3,
        K_PEEK   = 3'd4,
        K_EMPTY  = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_PUSHRD,
        S_PUSHOUT,
        S_HEADRD,
        S_OUT
    } state_t;

    // datapath -> controller
    typedef struct packed {
        cmd_t cmd;
        logic urg;
        logic cls_full;
        logic any_empty;
        logic urg_fail;     // total + len >= limit
        logic push_more;    // total + len > limit and normal not empty
    } stat_t;

    // controller -> datapath
    typedef struct packed {
        logic load;         // capture input item
        logic decide;       // finish enqueue into result register
        logic push_rd;      // read normal tail
        logic push_out;     // evict it, build pushout result
        logic head_rd;      // read class head
        logic head_out;     // build dequeue/peek/empty result
    } ctl_t;

endpackage

FILE: sv/tcq_ctrl.sv
// ----------------------------------------------------------------------------
// tcq_ctrl: controller
// Sequences enqueue, pushout and dequeue steps and the output register.
// ----------------------------------------------------------------------------
module tcq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  tcq_pkg::stat_t   stat,
    output tcq_pkg::ctl_t    ctl
);

    tcq_pkg::state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic free;

    assign free      = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tcq_pkg::S_IDLE:
                if (in_valid && in_ready)
                    state_next = tcq_pkg::S_DECIDE;
            tcq_pkg::S_DECIDE:
                priority if (stat.cmd == tcq_pkg::CMD_NOP)
                    state_next = tcq_pkg::S_IDLE;
                else if (stat.cmd != tcq_pkg::CMD_ENQ)
                    state_next = stat.any_empty ? tcq_pkg::S_OUT : tcq_pkg::S_HEADRD;
                else if (stat.urg && !stat.cls_full && stat.urg_fail && stat.push_more)
                    state_next = tcq_pkg::S_PUSHRD;
                else if (free)
                    state_next = tcq_pkg::S_OUT;
            tcq_pkg::S_PUSHRD:
                state_next = tcq_pkg::S_PUSHOUT;
            tcq_pkg::S_PUSHOUT:
                if (free)
                    state_next = tcq_pkg::S_DECIDE;
            tcq_pkg::S_HEADRD:
                state_next = tcq_pkg::S_OUT;
            tcq_pkg::S_OUT:
                if (free)
                    state_next = tcq_pkg::S_IDLE;
            default:
                state_next = tcq_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            tcq_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                ctl.load = in_valid;
            end
            tcq_pkg::S_PUSHRD:  ctl.push_rd = 1'b1;
            tcq_pkg::S_PUSHOUT: ctl.push_out = free;
            tcq_pkg::S_HEADRD:  ctl.head_rd = 1'b1;
            tcq_pkg::S_OUT:
            begin
                ctl.head_out = free && (stat.cmd != tcq_pkg::CMD_ENQ);
                ctl.decide   = free && (stat.cmd == tcq_pkg::CMD_ENQ);
            end
            default: ;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready)
            out_valid_next = 1'b0;
        if (ctl.push_out || ctl.decide || ctl.head_out)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcq_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: sv/tcq_dpath.sv
// ----------------------------------------------------------------------------
// tcq_dpath: datapath
// Class stores, pointers, byte counter, marking and the result register.
// ----------------------------------------------------------------------------
module tcq_dpath #(
    parameter int CLASS_DEPTH  = tcq_pkg::CLASS_DEPTH_DEF,
    parameter int HANDLE_WIDTH = tcq_pkg::HANDLE_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [tcq_pkg::BYTE_W-1:0] cfg_data,
    input  logic [1:0]                in_cmd,
    input  logic [HANDLE_WIDTH-1:0]   in_handle,
    input  logic [tcq_pkg::LEN_W-1:0] in_len,
    input  logic [3:0]                in_tag,
    input  logic                      in_ip,
    input  logic [tcq_pkg::TOS_W-1:0] in_tos,
    input  tcq_pkg::ctl_t             ctl,
    output tcq_pkg::stat_t            stat,
    output logic [2:0]                r_kind,
    output logic [HANDLE_WIDTH-1:0]   r_handle,
    output logic [tcq_pkg::LEN_W-1:0] r_len,
    output logic                      r_urg,
    output logic [tcq_pkg::TOS_W-1:0] r_tos,
    output logic                      r_marked,
    output logic                      r_full,
    output logic [tcq_pkg::BYTE_W-1:0] r_bytes,
    output logic                      r_last
);

    localparam int AW = $clog2(CLASS_DEPTH);
    localparam int CW = $clog2(CLASS_DEPTH + 1);
    localparam int DW = HANDLE_WIDTH + tcq_pkg::LEN_W + tcq_pkg::TOS_W;
    localparam int BW = tcq_pkg::BYTE_W;

    logic [DW-1:0] ustore [CLASS_DEPTH];
    logic [DW-1:0] nstore [CLASS_DEPTH];
    logic [DW-1:0] rd_reg;

    logic [BW-1:0] limit_reg, thresh_reg, total_reg;
    logic [AW-1:0] uhead_reg, nhead_reg;
    logic [CW-1:0] ucnt_reg, ncnt_reg;

    logic [1:0]                cmd_reg;
    logic [HANDLE_WIDTH-1:0]   hdl_reg;
    logic [tcq_pkg::LEN_W-1:0] len_reg;
    logic [3:0]                tag_reg;
    logic                      ip_reg;
    logic [tcq_pkg::TOS_W-1:0] tos_reg;

    logic urg, cls_full, mark, ecn_nz;
    logic [BW:0] sum;
    logic [tcq_pkg::TOS_W-1:0] tos_m;
    logic [3:0] cnt4;
    logic [AW-1:0] utail, ntail, nlast;
    logic [HANDLE_WIDTH-1:0]   rd_h;
    logic [tcq_pkg::LEN_W-1:0] rd_l;
    logic [tcq_pkg::TOS_W-1:0] rd_t;
    logic [BW-1:0] sub_total;

    function automatic logic [AW-1:0] wrap(input logic [CW:0] v);
        logic [CW:0] d;
        d = (CW+1)'(CLASS_DEPTH);
        return (v >= d) ? AW'(v - d) : AW'(v);
    endfunction

    assign urg = (tag_reg == tcq_pkg::TAG_URGENT) ||
                 (ip_reg && tos_reg[1:0] == 2'b11 && tag_reg == tcq_pkg::TAG_ECN);
    assign cls_full = urg ? (ucnt_reg >= CW'(CLASS_DEPTH))
                          : (ncnt_reg >= CW'(CLASS_DEPTH));
    assign sum = {1'b0, total_reg} + (BW+1)'(len_reg);
    assign ecn_nz = tos_reg[1:0] != 2'b00;
    assign mark = (sum >= {1'b0, thresh_reg}) && ip_reg && ecn_nz;
    // count field plus one; a count of 7 carries into bit 5
    assign cnt4 = {1'b0, tos_reg[4:2]} + 4'd1;
    assign tos_m = ((tos_reg | 8'h0F) & {2'b00, cnt4, 2'b00}) | 8'h03;
    assign utail = wrap((CW+1)'(uhead_reg) + (CW+1)'(ucnt_reg));
    assign ntail = wrap((CW+1)'(nhead_reg) + (CW+1)'(ncnt_reg));
    assign nlast = wrap((CW+1)'(nhead_reg) + (CW+1)'(ncnt_reg) - (CW+1)'(1));
    assign {rd_t, rd_l, rd_h} = rd_reg;
    assign sub_total = (BW'(rd_l) > total_reg) ? '0 : total_reg - BW'(rd_l);

    assign stat.cmd       = tcq_pkg::cmd_t'(cmd_reg);
    assign stat.urg       = urg;
    assign stat.cls_full  = cls_full;
    assign stat.any_empty = (ucnt_reg == '0) && (ncnt_reg == '0);
    assign stat.urg_fail  = sum >= {1'b0, limit_reg};
    assign stat.push_more = (sum > {1'b0, limit_reg}) && (ncnt_reg != '0);

    // stores and read port
    always_ff @(posedge clk)
    begin
        if (ctl.decide && !cls_full && !(sum >= {1'b0, limit_reg}))
        begin
            if (urg)
                ustore[utail] <= {tos_reg, len_reg, hdl_reg};
            else
                nstore[ntail] <= {mark ? tos_m : tos_reg, len_reg, hdl_reg};
        end
        if (ctl.push_rd)
            rd_reg <= nstore[nlast];
        else if (ctl.head_rd)
            rd_reg <= (ucnt_reg != '0) ? ustore[uhead_reg] : nstore[nhead_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= in_cmd;
            hdl_reg <= in_handle;
            len_reg <= in_len;
            tag_reg <= in_tag;
            ip_reg  <= in_ip;
            tos_reg <= in_tos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  <= tcq_pkg::LIMIT_RST;
            thresh_reg <= tcq_pkg::THRESH_RST;
            total_reg  <= '0;
            uhead_reg  <= '0;
            nhead_reg  <= '0;
            ucnt_reg   <= '0;
            ncnt_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == tcq_pkg::CFG_LIMIT)
                    limit_reg <= cfg_data;
                else
                    thresh_reg <= cfg_data;
            end
            if (ctl.decide && !cls_full && !(sum >= {1'b0, limit_reg}))
            begin
                total_reg <= sum[BW-1:0];
                if (urg)
                    ucnt_reg <= ucnt_reg + CW'(1);
                else
                    ncnt_reg <= ncnt_reg + CW'(1);
            end
            if (ctl.push_out)
            begin
                total_reg <= sub_total;
                ncnt_reg  <= ncnt_reg - CW'(1);
            end
            if (ctl.head_out && !stat.any_empty && cmd_reg == tcq_pkg::CMD_DEQ)
            begin
                total_reg <= sub_total;
                if (ucnt_reg != '0)
                begin
                    ucnt_reg  <= ucnt_reg - CW'(1);
                    uhead_reg <= wrap((CW+1)'(uhead_reg) + (CW+1)'(1));
                end
                else
                begin
                    ncnt_reg  <= ncnt_reg - CW'(1);
                    nhead_reg <= wrap((CW+1)'(nhead_reg) + (CW+1)'(1));
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (ctl.push_out)
        begin
            r_kind <= tcq_pkg::K_PUSH;  r_handle <= rd_h;  r_len <= rd_l;
            r_urg <= 1'b0;  r_tos <= rd_t;  r_marked <= 1'b0;  r_full <= 1'b0;
            r_bytes <= sub_total;  r_last <= 1'b0;
        end
        else if (ctl.decide)
        begin
            r_handle <= hdl_reg;  r_len <= len_reg;  r_urg <= urg;  r_last <= 1'b1;
            priority if (cls_full)
            begin
                r_kind <= tcq_pkg::K_DROP; r_tos <= tos_reg; r_marked <= 1'b0;
                r_full <= 1'b1; r_bytes <= total_reg;
            end
            else if (urg)
            begin
                r_kind <= (sum >= {1'b0, limit_reg}) ? tcq_pkg::K_DROP : tcq_pkg::K_ACCEPT;
                r_tos <= tos_reg; r_marked <= 1'b0; r_full <= 1'b0;
                r_bytes <= (sum >= {1'b0, limit_reg}) ? total_reg : sum[BW-1:0];
            end
            else
            begin
                r_kind <= (sum >= {1'b0, limit_reg}) ? tcq_pkg::K_DROP : tcq_pkg::K_ACCEPT;
                r_tos <= mark ? tos_m : tos_reg; r_marked <= mark; r_full <= 1'b0;
                r_bytes <= (sum >= {1'b0, limit_reg}) ? total_reg : sum[BW-1:0];
            end
        end
        else if (ctl.head_out)
        begin
            r_marked <= 1'b0;  r_full <= 1'b0;  r_last <= 1'b1;
            if (stat.any_empty)
            begin
                r_kind <= tcq_pkg::K_EMPTY; r_handle <= '0; r_len <= '0;
                r_urg <= 1'b0; r_tos <= '0; r_bytes <= total_reg;
            end
            else
            begin
                r_kind <= (cmd_reg == tcq_pkg::CMD_DEQ) ? tcq_pkg::K_DEQ : tcq_pkg::K_PEEK;
                r_handle <= rd_h; r_len <= rd_l; r_urg <= ucnt_reg != '0; r_tos <= rd_t;
                r_bytes <= (cmd_reg == tcq_pkg::CMD_DEQ) ? sub_total : total_reg;
            end
        end
    end

endmodule

FILE: sv/two_class_ecn_pushout_queue.sv
// ----------------------------------------------------------------------------
// two_class_ecn_pushout_queue: strict priority descriptor queue
// Two classes, shared byte limit, ECN marking and pushout of normal tail.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request (enqueue, dequeue or peek). Each request gives
//   one or more results on m_axis; tlast marks the final one. cmd 3 gives none.
//   cfg channel writes byte_limit (index 0) or mark_threshold (index 1); write
//   only while idle.
// Sequencing:
//   Enqueue without pushout: result follows accept through decide and output;
//   a new request is taken only after idle, decide and output in turn.
//   Dequeue/peek: decide, head read and output (registered store read);
//   on an empty queue the head read is skipped.
//   Each pushed-out descriptor adds decide, tail read and evict steps, served
//   by the single read port of the normal store. One request is worked at a
//   time; the next is taken once the final result is in the output register.
// Reset: counters, pointers and byte total clear, registers take defaults;
//   store contents stay undefined and are only read after being written.
// Stall: a held m_axis result is never overwritten; the sequencer waits.
// ----------------------------------------------------------------------------
module two_class_ecn_pushout_queue #(
    parameter int CLASS_DEPTH  = tcq_pkg::CLASS_DEPTH_DEF,
    parameter int HANDLE_WIDTH = tcq_pkg::HANDLE_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cmd[1:0], packet_handle, packet_length[15:0], priority_tag[3:0],
    // is_ipv4, tos_in[7:0], zero pad
    input  logic [((2+HANDLE_WIDTH+16+4+1+8+7)/8)*8-1:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // kind[2:0], handle_out, length_out[15:0], urgent_class, tos_out[7:0],
    // was_marked, store_full, bytes_queued[23:0], zero pad
    output logic [((3+HANDLE_WIDTH+16+1+8+1+1+24+7)/8)*8-1:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    localparam int H  = HANDLE_WIDTH;
    localparam int OW = 3 + H + 16 + 1 + 8 + 1 + 1 + 24;
    localparam int OT = ((OW + 7) / 8) * 8;

    tcq_pkg::stat_t stat;
    tcq_pkg::ctl_t  ctl;
    logic [2:0]   r_kind;
    logic [H-1:0] r_handle;
    logic [15:0]  r_len;
    logic         r_urg, r_marked, r_full, r_last;
    logic [7:0]   r_tos;
    logic [23:0]  r_bytes;

    assign cfg_ready = 1'b1;

    tcq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .ctl       (ctl)
    );

    tcq_dpath #(
        .CLASS_DEPTH  (CLASS_DEPTH),
        .HANDLE_WIDTH (HANDLE_WIDTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_cmd    (s_axis_tdata[1:0]),
        .in_handle (s_axis_tdata[2 +: H]),
        .in_len    (s_axis_tdata[2+H +: 16]),
        .in_tag    (s_axis_tdata[18+H +: 4]),
        .in_ip     (s_axis_tdata[22+H]),
        .in_tos    (s_axis_tdata[23+H +: 8]),
        .ctl       (ctl),
        .stat      (stat),
        .r_kind    (r_kind),
        .r_handle  (r_handle),
        .r_len     (r_len),
        .r_urg     (r_urg),
        .r_tos     (r_tos),
        .r_marked  (r_marked),
        .r_full    (r_full),
        .r_bytes   (r_bytes),
        .r_last    (r_last)
    );

    assign m_axis_tdata = OT'({r_bytes, r_full, r_marked, r_tos, r_urg, r_len,
                               r_handle, r_kind});
    assign m_axis_tlast = r_last;

endmodule

FILE: tb/two_class_ecn_pushout_queue_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_class_ecn_pushout_queue_checker: result predictor and scoreboard
// Watches the config, request and result channels, models both classes and
// the shared byte count, and compares every result with the oldest prediction.
// ----------------------------------------------------------------------------
module two_class_ecn_pushout_queue_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [71:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    output int          errors,
    output int          pending,
    output int          n_results,
    output int          n_pushed,
    output int          n_full
);

    localparam int DEPTH     = tcq_pkg::CLASS_DEPTH_DEF;
    localparam int DUE_DEPTH = 128;   // one request in flight, at most 33 results

    typedef struct packed {
        logic [15:0] handle;
        logic [15:0] len;
        logic [7:0]  tos;
    } desc_t;

    typedef struct packed {
        tcq_pkg::kind_t kind;
        logic [15:0]    handle;
        logic [15:0]    len;
        logic           urg;
        logic [7:0]     tos;
        logic           marked;
        logic           full;
        logic [23:0]    bytes;
        logic           last;
    } result_t;

    desc_t       urg_q [DEPTH];
    desc_t       nrm_q [DEPTH];
    int unsigned urg_head, urg_cnt, nrm_head, nrm_cnt;
    int unsigned total_bytes;
    int unsigned limit_bytes, mark_bytes;
    result_t     due_q [DUE_DEPTH];
    int unsigned due_wr, due_rd;

    assign pending = int'(due_wr - due_rd);

    function automatic void add_result(tcq_pkg::kind_t k, desc_t d, logic u, logic mk,
                                       logic fl, logic lst);
        result_t r;
        r.kind   = k;
        r.handle = d.handle;
        r.len    = d.len;
        r.urg    = u;
        r.tos    = d.tos;
        r.marked = mk;
        r.full   = fl;
        r.bytes  = total_bytes[23:0];
        r.last   = lst;
        due_q[due_wr % DUE_DEPTH] = r;
        due_wr++;
    endfunction

    function automatic void drop_bytes(int unsigned n);
        total_bytes = (n > total_bytes) ? 0 : total_bytes - n;
    endfunction

    function automatic void predict_request(logic [47:0] req);
        tcq_pkg::cmd_t c;
        desc_t         d;
        desc_t         v;
        logic [3:0]    tag;
        logic          ip;
        logic          u;
        logic          mk;
        logic [7:0]    m;
        int unsigned   need;
        c        = tcq_pkg::cmd_t'(req[1:0]);
        d.handle = req[17:2];
        d.len    = req[33:18];
        tag      = req[37:34];
        ip       = req[38];
        d.tos    = req[46:39];
        mk       = 1'b0;
        if (c == tcq_pkg::CMD_NOP)
            return;
        if (c == tcq_pkg::CMD_ENQ)
        begin
            u = (tag == tcq_pkg::TAG_URGENT) ||
                (ip && d.tos[1:0] == 2'b11 && tag == tcq_pkg::TAG_ECN);
            if ((u ? urg_cnt : nrm_cnt) >= DEPTH)
            begin
                add_result(tcq_pkg::K_DROP, d, u, 1'b0, 1'b1, 1'b1);
                return;
            end
            if (u)
            begin
                if (total_bytes + d.len >= limit_bytes)
                begin
                    // evict normal tail until the urgent packet fits
                    while (total_bytes + d.len > limit_bytes && nrm_cnt > 0)
                    begin
                        v = nrm_q[(nrm_head + nrm_cnt - 1) % DEPTH];
                        nrm_cnt--;
                        drop_bytes(v.len);
                        add_result(tcq_pkg::K_PUSH, v, 1'b0, 1'b0, 1'b0, 1'b0);
                    end
                    if (total_bytes + d.len >= limit_bytes)
                    begin
                        add_result(tcq_pkg::K_DROP, d, 1'b1, 1'b0, 1'b0, 1'b1);
                        return;
                    end
                end
                urg_q[(urg_head + urg_cnt) % DEPTH] = d;
                urg_cnt++;
                total_bytes += d.len;
                add_result(tcq_pkg::K_ACCEPT, d, 1'b1, 1'b0, 1'b0, 1'b1);
                return;
            end
            need = total_bytes + d.len;
            if (need >= mark_bytes && ip && d.tos[1:0] != 2'b00)
            begin
                m     = ({5'd0, d.tos[4:2]} + 8'd1) << 2;
                d.tos = ((d.tos | 8'h0F) & m) | 8'h03;
                mk    = 1'b1;
            end
            if (need >= limit_bytes)
            begin
                add_result(tcq_pkg::K_DROP, d, 1'b0, mk, 1'b0, 1'b1);
                return;
            end
            nrm_q[(nrm_head + nrm_cnt) % DEPTH] = d;
            nrm_cnt++;
            total_bytes += d.len;
            add_result(tcq_pkg::K_ACCEPT, d, 1'b0, mk, 1'b0, 1'b1);
            return;
        end
        // dequeue or peek: urgent class first
        if (urg_cnt == 0 && nrm_cnt == 0)
        begin
            add_result(tcq_pkg::K_EMPTY, '0, 1'b0, 1'b0, 1'b0, 1'b1);
        end
        else if (urg_cnt > 0)
        begin
            v = urg_q[urg_head];
            if (c == tcq_pkg::CMD_DEQ)
            begin
                urg_head = (urg_head + 1) % DEPTH;
                urg_cnt--;
                drop_bytes(v.len);
            end
            add_result(c == tcq_pkg::CMD_DEQ ? tcq_pkg::K_DEQ : tcq_pkg::K_PEEK,
                       v, 1'b1, 1'b0, 1'b0, 1'b1);
        end
        else
        begin
            v = nrm_q[nrm_head];
            if (c == tcq_pkg::CMD_DEQ)
            begin
                nrm_head = (nrm_head + 1) % DEPTH;
                nrm_cnt--;
                drop_bytes(v.len);
            end
            add_result(c == tcq_pkg::CMD_DEQ ? tcq_pkg::K_DEQ : tcq_pkg::K_PEEK,
                       v, 1'b0, 1'b0, 1'b0, 1'b1);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            urg_head    = 0;
            urg_cnt     = 0;
            nrm_head    = 0;
            nrm_cnt     = 0;
            total_bytes = 0;
            limit_bytes = tcq_pkg::LIMIT_RST;
            mark_bytes  = tcq_pkg::THRESH_RST;
            errors      = 0;
            n_results   = 0;
            n_pushed    = 0;
            n_full      = 0;
            due_wr      = 0;
            due_rd      = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.kind   = tcq_pkg::kind_t'(m_axis_tdata[2:0]);
                got.handle = m_axis_tdata[18:3];
                got.len    = m_axis_tdata[34:19];
                got.urg    = m_axis_tdata[35];
                got.tos    = m_axis_tdata[43:36];
                got.marked = m_axis_tdata[44];
                got.full   = m_axis_tdata[45];
                got.bytes  = m_axis_tdata[69:46];
                got.last   = m_axis_tlast;
                n_results++;
                if (got.kind == tcq_pkg::K_PUSH)
                    n_pushed++;
                if (got.full)
                    n_full++;
                if (due_wr == due_rd)
                begin
                    errors++;
                    $display("%0t: expected no result, actual %p", $time, got);
                end
                else
                begin
                    want = due_q[due_rd % DUE_DEPTH];
                    due_rd++;
                    if (got !== want)
                    begin
                        errors++;
                        $display("%0t: mismatch expected %p actual %p", $time, want, got);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == tcq_pkg::CFG_LIMIT)
                    limit_bytes = cfg_data;
                else
                    mark_bytes = cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_request(s_axis_tdata);
        end
    end

endmodule

FILE: tb/two_class_ecn_pushout_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_class_ecn_pushout_queue_tb: top level testbench
// Directed corner requests, then phases of random traffic under several
// limit/threshold settings, with bursty sender and stalling receiver.
// ----------------------------------------------------------------------------
module two_class_ecn_pushout_queue_tb;

    localparam int IDLE_LIMIT = 20000;  // cycles without any handshake
    localparam int DRAIN_GAP  = 20;     // covers a silent request, which gives no result

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [23:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tlast;

    int errors, pending, n_results, n_pushed, n_full;
    int n_sent;
    int burst_left;
    int stall_mode;
    int cyc;
    int idle_cycles;

    two_class_ecn_pushout_queue u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    two_class_ecn_pushout_queue_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .errors        (errors),
        .pending       (pending),
        .n_results     (n_results),
        .n_pushed      (n_pushed),
        .n_full        (n_full)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Receiver: stall style is redrawn at random from four modes; mode 0 gives
    // long stretches with no stall at all.
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc % 150 == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= ((cyc / 7) % 2 == 0);
        endcase
    end

    // Watchdog on handshake activity.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("FAIL two_class_ecn_pushout_queue");
            $finish;
        end
    end

    // One request; sender runs in bursts with random gaps between them.
    task automatic send_request(tcq_pkg::cmd_t c, logic [15:0] h, logic [15:0] len,
                                logic [3:0] tag, logic ip, logic [7:0] tos);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, tos, ip, tag, len, h, c};
        do
            @(posedge clk);
        while (!s_axis_tready);
        n_sent++;
    endtask

    // Let every outstanding result drain, then hold off a little more.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Random request; cls: 0 any tag, 1 urgent only, 2 normal only.
    task automatic random_request(int enq_pct, int len_max, int cls);
        int            r;
        tcq_pkg::cmd_t c;
        logic [3:0]    tag;
        logic [7:0]    tos;
        r   = $urandom_range(0, 99);
        tos = 8'($urandom_range(0, 255));
        if (r < enq_pct)
            c = tcq_pkg::CMD_ENQ;
        else if (r < enq_pct + (100 - enq_pct) * 6 / 10)
            c = tcq_pkg::CMD_DEQ;
        else if (r < 97)
            c = tcq_pkg::CMD_PEEK;
        else
            c = tcq_pkg::CMD_NOP;
        case (cls)
            1:       tag = tcq_pkg::TAG_URGENT;
            2:       tag = $urandom_range(0, 1) ? 4'h0 : 4'hA;
            default: tag = $urandom_range(0, 2) == 0 ? tcq_pkg::TAG_URGENT :
                           ($urandom_range(0, 1) ? tcq_pkg::TAG_ECN
                                                 : 4'($urandom_range(0, 15)));
        endcase
        send_request(c, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, len_max)),
                     tag, 1'($urandom_range(0, 1)), tos);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = tcq_pkg::CFG_LIMIT;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        stall_mode    = 0;
        cyc           = 0;
        idle_cycles   = 0;
        n_sent        = 0;
        burst_left    = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty queue, unused command, marking cases, field extremes.
        send_request(tcq_pkg::CMD_DEQ,  16'h0000, 16'h0000, 4'h0, 1'b0, 8'h00);
        send_request(tcq_pkg::CMD_PEEK, 16'h0000, 16'h0000, 4'h0, 1'b0, 8'h00);
        send_request(tcq_pkg::CMD_NOP,  16'hFFFF, 16'hFFFF, 4'hF, 1'b1, 8'hFF);
        send_request(tcq_pkg::CMD_ENQ,  16'h0001, 16'd100,  4'h0, 1'b1, 8'h01); // marked
        send_request(tcq_pkg::CMD_ENQ,  16'h0002, 16'd100,  4'h0, 1'b1, 8'h1C); // ECN 0
        send_request(tcq_pkg::CMD_ENQ,  16'h0003, 16'd100,  4'h0, 1'b0, 8'h03); // not IPv4
        send_request(tcq_pkg::CMD_ENQ,  16'h0004, 16'd0,    4'h0, 1'b1, 8'hFF); // count wraps
        send_request(tcq_pkg::CMD_ENQ,  16'hFFFF, 16'hFFFF, tcq_pkg::TAG_URGENT, 1'b0, 8'hFF);
        // urgent by ECN, then the same tag without IPv4 stays normal
        send_request(tcq_pkg::CMD_ENQ,  16'h0005, 16'd10,   tcq_pkg::TAG_ECN, 1'b1, 8'h03);
        send_request(tcq_pkg::CMD_ENQ,  16'h0006, 16'd10,   tcq_pkg::TAG_ECN, 1'b0, 8'h03);
        send_request(tcq_pkg::CMD_PEEK, 16'h0000, 16'h0000, 4'h0, 1'b0, 8'h00);
        repeat (4) send_request(tcq_pkg::CMD_DEQ, 16'h0000, 16'h0000, 4'h0, 1'b0, 8'h00);
        send_request(tcq_pkg::CMD_PEEK, 16'h0000, 16'h0000, 4'h0, 1'b0, 8'h00);
        repeat (3) send_request(tcq_pkg::CMD_DEQ, 16'h0000, 16'h0000, 4'h0, 1'b0, 8'h00);
        wait_drained();

        // Small limit: pushout of the normal tail, then urgent drop.
        write_reg(tcq_pkg::CFG_LIMIT, 24'd100);
        write_reg(tcq_pkg::CFG_THRESH, 24'd50);
        send_request(tcq_pkg::CMD_ENQ, 16'h0010, 16'd30, 4'h0, 1'b1, 8'h02);
        send_request(tcq_pkg::CMD_ENQ, 16'h0011, 16'd30, 4'h0, 1'b1, 8'h02);
        send_request(tcq_pkg::CMD_ENQ, 16'h0012, 16'd30, 4'h0, 1'b1, 8'h02);
        send_request(tcq_pkg::CMD_ENQ, 16'h0013, 16'd75, tcq_pkg::TAG_URGENT, 1'b0, 8'h00);
        send_request(tcq_pkg::CMD_ENQ, 16'h0014, 16'd200, tcq_pkg::TAG_URGENT, 1'b0, 8'h00);
        wait_drained();

        // Random phases, each under its own setting.
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(tcq_pkg::CFG_LIMIT, 24'd3000);
                    write_reg(tcq_pkg::CFG_THRESH, 24'd1000);
                end
                1:
                begin
                    write_reg(tcq_pkg::CFG_LIMIT, 24'd0);
                    write_reg(tcq_pkg::CFG_THRESH, 24'd0);
                end
                2:
                begin
                    write_reg(tcq_pkg::CFG_LIMIT, 24'hFFFFFF);
                    write_reg(tcq_pkg::CFG_THRESH, 24'hFFFFFF);
                end
                3:
                begin
                    write_reg(tcq_pkg::CFG_LIMIT, 24'd20000);
                    write_reg(tcq_pkg::CFG_THRESH, 24'd0);
                end
                default:
                begin
                    write_reg(tcq_pkg::CFG_LIMIT, tcq_pkg::LIMIT_RST);
                    write_reg(tcq_pkg::CFG_THRESH, tcq_pkg::THRESH_RST);
                end
            endcase
            if (ph == 2)
            begin
                // fill both classes past their depth, then issue dequeue, peek and unused requests
                repeat (36) random_request(100, 65535, 1);
                repeat (36) random_request(100, 65535, 2);
                repeat (20) random_request(0, 0, 0);
            end
            else
            begin
                repeat (80) random_request(ph == 0 ? 65 : 55, ph == 0 ? 1500 : 65535, 0);
            end
            wait_drained();
        end

        $display("sent %0d requests, checked %0d results (%0d pushouts, %0d store-full drops)",
                 n_sent, n_results, n_pushed, n_full);
        $display("settings covered: default, tiny, zero, maximum and mid limits");
        if (errors == 0)
            $display("PASS two_class_ecn_pushout_queue");
        else
            $display("FAIL two_class_ecn_pushout_queue");
        $finish;
    end

endmodule
